>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, sampled on clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only
`define VCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included
`define VCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hdl/vcf_pkg.sv
// ----------------------------------------------------------------------------
// vcf_pkg
// Widths, codes and shared types of the valid-mode convolution FIR.
// ----------------------------------------------------------------------------
package vcf_pkg;

  localparam int TAPS_MAX = 32;
  localparam int AddrW    = $clog2(TAPS_MAX);
  localparam int CntW     = $clog2(TAPS_MAX + 1);
  localparam int WinDepth = 1 << AddrW;

  localparam int IdxW    = 5;
  localparam int CoefW   = 16;
  localparam int SmpW    = 16;
  localparam int CfgW    = 6;
  localparam int ProdW   = 32;
  localparam int ResultW = 37;

  localparam logic CMD_TAP    = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_e;

  // Control travelling alongside the MAC operands
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

>>> hdl/vcf_if.sv
// ----------------------------------------------------------------------------
// vcf channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface vcf_in_if
  import vcf_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [IdxW-1:0]         tap_index;
  logic signed [CoefW-1:0] tap_value;
  logic signed [SmpW-1:0]  sample;
  logic                    first;

  modport source (output valid, command, tap_index, tap_value, sample, first,
                  input ready);
  modport sink   (input valid, command, tap_index, tap_value, sample, first,
                  output ready);
endinterface

interface vcf_out_if
  import vcf_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [ResultW-1:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

>>> hdl/vcf_mac.sv
// ----------------------------------------------------------------------------
// vcf_mac
// Shared multiply-accumulate: registered product, then full-width sum.
// ----------------------------------------------------------------------------
module vcf_mac
  import vcf_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mac_ctl_t                  ctl_i,
  input  logic signed [CoefW-1:0]   tap_i,
  input  logic signed [SmpW-1:0]    smp_i,
  output logic signed [ResultW-1:0] acc_o,
  output logic                      done_o
);

  logic signed [ProdW-1:0]   prod_q;
  mac_ctl_t                  p_ctl_q;
  logic signed [ResultW-1:0] acc_q, acc_d;
  logic                      done_q;

  always_ff @(posedge clk_i) begin
    prod_q <= tap_i * smp_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_ctl_q <= '0;
      done_q  <= 1'b0;
    end else begin
      p_ctl_q <= ctl_i;
      done_q  <= p_ctl_q.vld & p_ctl_q.last;
    end
  end

  // restart the sum on the first product of a window
  always_comb begin
    acc_d = acc_q;
    if (p_ctl_q.vld) begin
      acc_d = (p_ctl_q.first ? ResultW'(0) : acc_q) + ResultW'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

>>> hdl/valid_conv1d_fir_core.sv
// ----------------------------------------------------------------------------
// valid_conv1d_fir_core
// Streaming valid-mode 1D correlation with a tap store and a sample ring.
// ----------------------------------------------------------------------------
// Tap writes, and samples that do not yet complete a window, are taken in
// the idle state and may arrive back to back. A sample that completes a
// window of K taps (K = tap_count clamped to 1..TAPS_MAX) holds the input
// through the run: one read of the tap memory and the sample ring per tap
// feeding a single shared multiply-accumulate, a drain of the read and MAC
// registers, and a load of the output register. A waiting result does not
// stop the next item from being taken; a second result waits for the first.
module valid_conv1d_fir_core
  import vcf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  vcf_in_if.sink          in_ch_i,
  vcf_out_if.source       out_ch_o
);

`include "assert_macros.svh"

  state_e            state_q, state_d;
  logic [CfgW-1:0]   tap_count_q;
  logic [CntW-1:0]   k_eff;
  logic [CntW-1:0]   fill_q, fill_d, fill_new;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [AddrW-1:0]  rp_q, rp_d;
  logic [AddrW-1:0]  wp_q, wp_d;
  logic              in_acc, issue, last_issue, out_free, out_load;
  logic              tap_we, win_we;
  logic [AddrW-1:0]  tap_wr_addr;
  logic [TAPS_MAX-1:0] tap_vld_q;
  mac_ctl_t          rd_ctl_q, rd_ctl_d;
  logic              mac_done;
  logic signed [ResultW-1:0] mac_acc;
  logic signed [CoefW-1:0]   tap_rd_q, tap_op;
  logic                      tap_hit_q;
  logic signed [SmpW-1:0]    smp_rd_q;
  logic                      out_vld_q, out_vld_d;
  logic signed [ResultW-1:0] out_res_q;

  logic signed [CoefW-1:0] tap_mem_q [TAPS_MAX];
  logic signed [SmpW-1:0]  win_mem_q [WinDepth];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      tap_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    priority if (tap_count_q == '0) begin
      k_eff = CntW'(1);
    end else if (32'(tap_count_q) > TAPS_MAX) begin
      k_eff = CntW'(TAPS_MAX);
    end else begin
      k_eff = CntW'(tap_count_q);
    end
  end

  assign in_ch_i.ready = (state_q == ST_IDLE);
  assign in_acc        = in_ch_i.valid & in_ch_i.ready;

  assign tap_we      = in_acc && (in_ch_i.command == CMD_TAP) &&
                       (32'(in_ch_i.tap_index) < TAPS_MAX);
  assign tap_wr_addr = AddrW'(in_ch_i.tap_index);
  assign win_we      = in_acc && (in_ch_i.command == CMD_SAMPLE);

  // a first flag restarts the fill; otherwise advance and saturate
  always_comb begin
    if (in_ch_i.first) begin
      fill_new = CntW'(1);
    end else if (fill_q == CntW'(TAPS_MAX)) begin
      fill_new = fill_q;
    end else begin
      fill_new = fill_q + CntW'(1);
    end
  end

  assign issue      = (state_q == ST_RUN);
  assign last_issue = issue && (CntW'(idx_q) == (k_eff - CntW'(1)));
  assign out_free   = !out_vld_q || out_ch_o.ready;
  assign out_load   = (state_q == ST_HOLD) && out_free;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    rp_d    = rp_q;
    wp_d    = wp_q;
    fill_d  = fill_q;
    unique case (state_q)
      ST_IDLE: begin
        if (win_we) begin
          wp_d   = wp_q + AddrW'(1);
          fill_d = fill_new;
          if (fill_new >= k_eff) begin
            state_d = ST_RUN;
            idx_d   = '0;
            // oldest sample of the window: newest position minus (K - 1)
            rp_d    = wp_q + AddrW'(2) - AddrW'(k_eff);
          end
        end
      end
      ST_RUN: begin
        idx_d = idx_q + AddrW'(1);
        rp_d  = rp_q + AddrW'(1);
        if (last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_ctl_d.vld   = issue;
    rd_ctl_d.first = issue && (idx_q == '0);
    rd_ctl_d.last  = last_issue;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ch_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      rp_q      <= '0;
      wp_q      <= '0;
      fill_q    <= '0;
      rd_ctl_q  <= '0;
      out_vld_q <= 1'b0;
      tap_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      rp_q      <= rp_d;
      wp_q      <= wp_d;
      fill_q    <= fill_d;
      rd_ctl_q  <= rd_ctl_d;
      out_vld_q <= out_vld_d;
      if (tap_we) begin
        tap_vld_q[tap_wr_addr] <= 1'b1;
      end
    end
  end

  // tap store; a tap never written reads as zero
  always_ff @(posedge clk_i) begin
    if (tap_we) begin
      tap_mem_q[tap_wr_addr] <= in_ch_i.tap_value;
    end
    tap_rd_q  <= tap_mem_q[idx_q];
    tap_hit_q <= tap_vld_q[idx_q];
  end

  // sample ring; the write lands before the first read of a window
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem_q[wp_q + AddrW'(1)] <= in_ch_i.sample;
    end
    smp_rd_q <= win_mem_q[rp_q];
  end

  assign tap_op = tap_hit_q ? tap_rd_q : '0;

  vcf_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (rd_ctl_q),
    .tap_i  (tap_op),
    .smp_i  (smp_rd_q),
    .acc_o  (mac_acc),
    .done_o (mac_done)
  );

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q <= mac_acc;
    end
  end

  assign out_ch_o.valid  = out_vld_q;
  assign out_ch_o.result = out_res_q;

  `VCF_ASSERT(a_issue_in_range, (state_q == ST_RUN) |-> (CntW'(idx_q) < k_eff), "tap index past K")
  `VCF_ASSERT(a_mac_busy, rd_ctl_q.vld |-> (state_q == ST_RUN || state_q == ST_DRAIN), "stray MAC op")
  `VCF_ASSERT(a_done_drain, mac_done |-> (state_q == ST_DRAIN), "MAC done outside drain")
  `VCF_ASSERT_ALWAYS(a_fill_cap, !rst_ni || (fill_q <= CntW'(TAPS_MAX)), "window fill over capacity")

endmodule
